FILE: hdl/bidirectional_position_map_unit_macros.svh
// ----------------------------------------------------------------------------
// bidirectional_position_map_unit_macros.svh
// assertion macros used by the position map top level
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_POSITION_MAP_UNIT_MACROS_SVH
`define BIDIRECTIONAL_POSITION_MAP_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define BPM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bpm assertion failed");

// consequence holds in the cycle after the antecedent
`define BPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpm assertion failed");

// delayed form: consequence must hold after the antecedent
`define BPM_ASSERT_LATER(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("bpm assertion failed");

`endif

FILE: hdl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// types and constants of the bidirectional position map
// ----------------------------------------------------------------------------
`default_nettype none

package bpm_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 4096;
   localparam int ENTRY_WIDTH_DEFAULT = 32;
   localparam int ACTION_WIDTH        = 3;
   localparam int INDEX_WIDTH         = 32;
   localparam int VALUE_WIDTH         = 32;
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      OP_LOOKUP  = 3'd0,
      OP_SAVE    = 3'd1,
      OP_MOVE    = 3'd2,
      OP_PRE_FWD = 3'd3,
      OP_PRE_REV = 3'd4
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   a_ok;
      logic [INDEX_WIDTH-1:0] index_a;
      logic [INDEX_WIDTH-1:0] index_b;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic start_lookup;
      logic finishing;
   } back_status_type;

endpackage

`default_nettype wire

FILE: hdl/bpm_channels.sv
// ----------------------------------------------------------------------------
// bpm_channels
// valid/ready channels of the position map: request and response
// ----------------------------------------------------------------------------
`default_nettype none

interface bpm_req_if;
   logic                            valid;
   logic                            ready;
   logic [bpm_pkg::ACTION_WIDTH-1:0] action;
   logic [bpm_pkg::INDEX_WIDTH-1:0]  index_a;
   logic [bpm_pkg::INDEX_WIDTH-1:0]  index_b;

   modport source (output valid, action, index_a, index_b, input ready);
   modport sink   (input valid, action, index_a, index_b, output ready);
endinterface

interface bpm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bpm_pkg::VALUE_WIDTH-1:0]  entry_value;

   modport source (output valid, entry_value, input ready);
   modport sink   (input valid, entry_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/bidirectional_position_map_unit.sv
// ----------------------------------------------------------------------------
// bidirectional_position_map_unit
// linked forward and reverse position tables with lookup, save, move and
// preload actions
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  req_chan  in    action, index_a, index_b
//  rsp_chan  out   entry_value (lookup only)
//
//  lookup and move go through issue and finish in the back unit (registered
//  table read, then answer or dependent write); save and preload write in issue
//  the front takes one beat a cycle into a two-entry queue while it is not full
//  tables are not cleared after reset; an unwritten entry reads as garbage
//  the response register holds its beat while rsp_chan is stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "bidirectional_position_map_unit_macros.svh"

module bidirectional_position_map_unit #(
   parameter int TABLE_DEPTH = bpm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = bpm_pkg::ENTRY_WIDTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   bpm_req_if.sink   req_chan,
   bpm_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(TABLE_DEPTH);

   bpm_pkg::cmd_type          front_cmd;
   logic                      q_push;
   bpm_pkg::cmd_type          q_head;
   logic                      q_head_valid;
   logic                      q_pop;
   bpm_pkg::queue_status_type q_status;
   bpm_pkg::back_status_type  back_status;

   logic                   fwd_we, rev_we;
   logic [AW-1:0]          fwd_waddr, fwd_raddr, rev_waddr, rev_raddr;
   logic [ENTRY_WIDTH-1:0] fwd_wdata, fwd_rdata, rev_wdata, rev_rdata;

   bpm_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .req      (req_chan),
      .q_status (q_status),
      .push     (q_push),
      .cmd      (front_cmd)
   );

   bpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .cmd_in     (front_cmd),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid),
      .status     (q_status)
   );

   bpm_back #(.TABLE_DEPTH(TABLE_DEPTH), .ENTRY_WIDTH(ENTRY_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .fwd_we     (fwd_we),
      .fwd_waddr  (fwd_waddr),
      .fwd_wdata  (fwd_wdata),
      .fwd_raddr  (fwd_raddr),
      .fwd_rdata  (fwd_rdata),
      .rev_we     (rev_we),
      .rev_waddr  (rev_waddr),
      .rev_wdata  (rev_wdata),
      .rev_raddr  (rev_raddr),
      .rev_rdata  (rev_rdata),
      .rsp        (rsp_chan),
      .status     (back_status)
   );

   bpm_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(TABLE_DEPTH)) u_fwd_ram (
      .clock (clock),
      .we    (fwd_we),
      .waddr (fwd_waddr),
      .wdata (fwd_wdata),
      .raddr (fwd_raddr),
      .rdata (fwd_rdata)
   );

   bpm_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(TABLE_DEPTH)) u_rev_ram (
      .clock (clock),
      .we    (rev_we),
      .waddr (rev_waddr),
      .wdata (rev_wdata),
      .raddr (rev_raddr),
      .rdata (rev_rdata)
   );

   `BPM_ASSERT_ALWAYS(a_no_overflow, clock, reset, !(q_push && q_status.full))
   `BPM_ASSERT_ALWAYS(a_pop_has_entry, clock, reset, !(q_pop && q_status.empty))
   `BPM_ASSERT_NEXT(a_finish_once, clock, reset, back_status.finishing, !back_status.finishing)
   `BPM_ASSERT_LATER(a_lookup_answers, clock, reset, back_status.start_lookup, rsp_chan.valid)

endmodule

`default_nettype wire

FILE: hdl/bpm_ram.sv
// ----------------------------------------------------------------------------
// bpm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_ram #(
   parameter int WIDTH = bpm_pkg::ENTRY_WIDTH_DEFAULT,
   parameter int DEPTH = bpm_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/bpm_queue.sv
// ----------------------------------------------------------------------------
// bpm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bpm_pkg::cmd_type          cmd_in,
   input  wire logic                      pop,
   output bpm_pkg::cmd_type               head,
   output logic                           head_valid,
   output bpm_pkg::queue_status_type      status
);

   localparam int PW = $clog2(bpm_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(bpm_pkg::QUEUE_DEPTH + 1);

   bpm_pkg::cmd_type mem_ff [bpm_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(bpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(bpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != '0);
   assign status.full  = (count_ff == CW'(bpm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

FILE: hdl/bpm_front.sv
// ----------------------------------------------------------------------------
// bpm_front
// request intake: range checks and filtering of actions with no effect
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_front #(
   parameter int TABLE_DEPTH = bpm_pkg::TABLE_DEPTH_DEFAULT
) (
   bpm_req_if.sink                    req,
   input  wire bpm_pkg::queue_status_type q_status,
   output logic                       push,
   output bpm_pkg::cmd_type           cmd
);

   localparam int IW = bpm_pkg::INDEX_WIDTH;

   logic a_ok;
   logic b_ok;
   logic keep;

   assign a_ok = (req.index_a < IW'(TABLE_DEPTH));
   assign b_ok = (req.index_b < IW'(TABLE_DEPTH));

   always_comb begin
      unique case (bpm_pkg::op_type'(req.action))
         bpm_pkg::OP_LOOKUP:  keep = 1'b1;
         bpm_pkg::OP_SAVE:    keep = a_ok && b_ok;
         bpm_pkg::OP_MOVE:    keep = a_ok && b_ok;
         bpm_pkg::OP_PRE_FWD: keep = a_ok;
         bpm_pkg::OP_PRE_REV: keep = a_ok;
         default:             keep = 1'b0;
      endcase
   end

   assign req.ready   = !q_status.full;
   assign push        = req.valid && !q_status.full && keep;
   assign cmd.op      = bpm_pkg::op_type'(req.action);
   assign cmd.a_ok    = a_ok;
   assign cmd.index_a = req.index_a;
   assign cmd.index_b = req.index_b;

endmodule

`default_nettype wire

FILE: hdl/bpm_back.sv
// ----------------------------------------------------------------------------
// bpm_back
// command execution against the forward and reverse tables
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_back #(
   parameter int TABLE_DEPTH = bpm_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = bpm_pkg::ENTRY_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bpm_pkg::cmd_type               head,
   input  wire logic                           head_valid,
   output logic                                pop,
   output logic                                fwd_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]      fwd_waddr,
   output logic [ENTRY_WIDTH-1:0]              fwd_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]      fwd_raddr,
   input  wire logic [ENTRY_WIDTH-1:0]         fwd_rdata,
   output logic                                rev_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]      rev_waddr,
   output logic [ENTRY_WIDTH-1:0]              rev_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0]      rev_raddr,
   input  wire logic [ENTRY_WIDTH-1:0]         rev_rdata,
   bpm_rsp_if.source                           rsp,
   output bpm_pkg::back_status_type            status
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = bpm_pkg::INDEX_WIDTH;
   localparam int VW = bpm_pkg::VALUE_WIDTH;
   localparam logic [ENTRY_WIDTH-1:0] ENTRY_ONES = '1;

   typedef enum logic [1:0] {
      ST_ISSUE  = 2'b01,
      ST_FINISH = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic          is_lookup_ff;
   logic          a_ok_ff;
   logic [IW-1:0] b_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_data_ff, rsp_data_in;
   logic          out_free;
   logic [IW-1:0] c_ext;
   logic          c_ok;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign c_ext    = IW'(rev_rdata);
   assign c_ok     = (c_ext < IW'(TABLE_DEPTH));

   always_comb begin
      pop          = 1'b0;
      state_in     = state_ff;
      fwd_we       = 1'b0;
      rev_we       = 1'b0;
      fwd_raddr    = head.index_a[AW-1:0];
      rev_raddr    = head.index_a[AW-1:0];
      fwd_waddr    = head.index_a[AW-1:0];
      fwd_wdata    = head.index_b[ENTRY_WIDTH-1:0];
      rev_waddr    = head.index_b[AW-1:0];
      rev_wdata    = head.index_a[ENTRY_WIDTH-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_ISSUE: begin
            if (head_valid) begin
               unique case (head.op)
                  bpm_pkg::OP_LOOKUP: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        state_in = ST_FINISH;
                     end
                  end
                  bpm_pkg::OP_MOVE: begin
                     pop      = 1'b1;
                     state_in = ST_FINISH;
                  end
                  bpm_pkg::OP_SAVE: begin
                     pop    = 1'b1;
                     fwd_we = 1'b1;
                     rev_we = 1'b1;
                  end
                  bpm_pkg::OP_PRE_FWD: begin
                     pop    = 1'b1;
                     fwd_we = 1'b1;
                  end
                  bpm_pkg::OP_PRE_REV: begin
                     pop       = 1'b1;
                     rev_we    = 1'b1;
                     rev_waddr = head.index_a[AW-1:0];
                     rev_wdata = head.index_b[ENTRY_WIDTH-1:0];
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_FINISH: begin
            state_in = ST_ISSUE;
            if (is_lookup_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = a_ok_ff ? VW'(fwd_rdata) : VW'(ENTRY_ONES);
            end else if (c_ok) begin
               rev_we    = 1'b1;
               rev_waddr = b_ff[AW-1:0];
               rev_wdata = rev_rdata;
               fwd_we    = 1'b1;
               fwd_waddr = c_ext[AW-1:0];
               fwd_wdata = b_ff[ENTRY_WIDTH-1:0];
            end
         end
         default: state_in = ST_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         is_lookup_ff <= (head.op == bpm_pkg::OP_LOOKUP);
         a_ok_ff      <= head.a_ok;
         b_ff         <= head.index_b;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.entry_value     = rsp_data_ff;
   assign status.start_lookup = pop && (head.op == bpm_pkg::OP_LOOKUP);
   assign status.finishing    = (state_ff == ST_FINISH);

endmodule

`default_nettype wire
